// ===== hdl/msd_pkg.sv =====
package msd_pkg;

   localparam int MaxSamples = 16;
   localparam int IdxW = $clog2(MaxSamples);
   localparam int CntW = $clog2(MaxSamples + 1);
   localparam int SumW = 16 + CntW + 1;
   localparam logic [7:0] MotionBit = 8'h80;
   localparam logic [14:0] ResetReject = 15'd250;

   localparam logic [0:0] CsrMode = 1'd0;
   localparam logic [0:0] CsrReject = 1'd1;

   typedef struct packed {
      logic [7:0]         status_byte;
      logic signed [15:0] raw_x;
      logic signed [15:0] raw_y;
      logic               last_sample;
   } req_type;

   typedef struct packed {
      logic signed [23:0] x_value;
      logic signed [23:0] y_value;
      logic               motion_seen;
   } rsp_type;

   // classified reading handed from front to back
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               motion;
      logic               last;
   } smp_type;

endpackage

// ===== hdl/msd_front.sv =====
module msd_front
   import msd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   input  logic [14:0]   reject_limit,
   output logic          q_valid,
   input  logic          q_ready,
   output smp_type       q_data
);

   smp_type   que_ff [2];
   logic      wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   smp_type   cls;
   logic      push, pop;

   function automatic logic signed [15:0] lim(input logic signed [15:0] d,
                                              input logic [14:0] l);
      logic [16:0] mag;
      mag = d[15] ? 17'(-$signed({d[15], d})) : {1'b0, d};
      return (mag > {2'b0, l}) ? 16'sd0 : d;
   endfunction

   always_comb begin
      cls.motion = (req_data.status_byte & MotionBit) != 8'd0;
      cls.last = req_data.last_sample;
      cls.x = cls.motion ? lim(req_data.raw_x, reject_limit) : 16'sd0;
      cls.y = cls.motion ? lim(req_data.raw_y, reject_limit) : 16'sd0;
   end

   assign req_stall = cnt_ff == 2'd2;
   assign push = req_valid && !req_stall;
   assign q_valid = cnt_ff != 2'd0;
   assign q_data = que_ff[rp_ff];
   assign pop = q_valid && q_ready;

   always_ff @(posedge clock) begin
      if (push) que_ff[wp_ff] <= cls;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push || pop) else $error("queue overflow");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("bad queue count");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != 2'd0) else $error("pop from empty queue");

endmodule

// ===== hdl/msd_back.sv =====
module msd_back
   import msd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   output logic     q_ready,
   input  smp_type  q_data,
   input  logic     mode,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   typedef enum logic [2:0] {
      S_COLLECT, S_MAX, S_SORT, S_MEAN, S_DIV, S_DONE
   } state_type;

   state_type state_ff;
   logic signed [15:0] xs_ff [MaxSamples];
   logic signed [15:0] ys_ff [MaxSamples];
   logic [CntW-1:0] cnt_ff, i_ff;
   logic            any_ff;
   logic [IdxW-1:0] xmi_ff, ymi_ff;
   logic            ax_ff;         // axis under work: 0 x, 1 y
   logic            pass_ff;       // sort pass parity
   logic [CntW-1:0] sw_ff;         // sort passes done
   logic signed [SumW-1:0] sum_ff;
   logic signed [SumW+8:0] rem_ff;
   logic [SumW+8:0] quo_ff;
   logic            neg_ff;
   logic [5:0]      bit_ff;
   logic signed [23:0] rx_ff, ry_ff;
   logic            rv_ff;

   logic            take;
   logic [IdxW-1:0] ii;
   logic [CntW-1:0] m;
   logic signed [15:0] cur;

   assign q_ready = state_ff == S_COLLECT && !rv_ff;
   assign take = q_valid && q_ready;
   assign ii = i_ff[IdxW-1:0];
   assign m = cnt_ff - CntW'(1);
   assign cur = ax_ff ? ys_ff[ii] : xs_ff[ii];
   assign rsp_valid = rv_ff;
   assign rsp_data = '{x_value: rx_ff, y_value: ry_ff, motion_seen: any_ff};

   function automatic logic signed [23:0] sh8(input logic signed [15:0] v);
      return {v, 8'd0};
   endfunction

   always_ff @(posedge clock) begin
      logic [CntW-1:0] cnt_n;
      logic signed [23:0] r;
      logic [IdxW-1:0] a, b, mh;
      logic signed [15:0] va, vb;
      logic [SumW+8:0] mag;
      r = '0;
      cnt_n = cnt_ff;
      if (reset) begin
         state_ff <= S_COLLECT;
         cnt_ff <= '0;
         any_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         if (rv_ff && !rsp_stall) begin
            rv_ff <= 1'b0;
            any_ff <= 1'b0;
         end
         case (state_ff)
            S_COLLECT: if (take) begin
               if (cnt_ff < CntW'(MaxSamples)) begin
                  xs_ff[cnt_ff[IdxW-1:0]] <= q_data.x;
                  ys_ff[cnt_ff[IdxW-1:0]] <= q_data.y;
                  cnt_n = cnt_ff + CntW'(1);
               end
               any_ff <= any_ff | q_data.motion;
               if (q_data.last) begin
                  if (cnt_n <= CntW'(1)) begin
                     rx_ff <= (cnt_n == '0) ? '0
                        : sh8(cnt_ff == '0 ? q_data.x : xs_ff[0]);
                     ry_ff <= (cnt_n == '0) ? '0
                        : sh8(cnt_ff == '0 ? q_data.y : ys_ff[0]);
                     rv_ff <= 1'b1;
                  end else begin
                     state_ff <= S_MAX;
                     ax_ff <= 1'b0;
                     i_ff <= CntW'(1);
                     xmi_ff <= '0;
                     ymi_ff <= '0;
                  end
               end
               cnt_ff <= (q_data.last && cnt_n <= CntW'(1)) ? '0 : cnt_n;
            end
            S_MAX: begin
               // one index per cycle, both axes at once; first max kept
               if (xs_ff[ii] > xs_ff[xmi_ff]) xmi_ff <= ii;
               if (ys_ff[ii] > ys_ff[ymi_ff]) ymi_ff <= ii;
               if (i_ff == m) begin
                  i_ff <= '0;
                  sum_ff <= '0;
                  pass_ff <= 1'b0;
                  sw_ff <= '0;
                  state_ff <= mode ? S_SORT : S_MEAN;
               end else i_ff <= i_ff + CntW'(1);
            end
            S_SORT: begin
               // odd-even transposition, one compare-swap per cycle
               if (i_ff == '0) begin
                  // first cycle of axis: move max to the end
                  a = ax_ff ? ymi_ff : xmi_ff;
                  b = m[IdxW-1:0];
                  if (a != b) begin
                     if (ax_ff) begin
                        ys_ff[a] <= ys_ff[b]; ys_ff[b] <= ys_ff[a];
                     end else begin
                        xs_ff[a] <= xs_ff[b]; xs_ff[b] <= xs_ff[a];
                     end
                  end
                  i_ff <= CntW'(1);
               end else begin
                  a = IdxW'(i_ff - CntW'(1));
                  b = IdxW'(i_ff);
                  va = ax_ff ? ys_ff[a] : xs_ff[a];
                  vb = ax_ff ? ys_ff[b] : xs_ff[b];
                  if (CntW'(a[0]) == CntW'(pass_ff) && i_ff < m && va > vb) begin
                     if (ax_ff) begin
                        ys_ff[a] <= vb; ys_ff[b] <= va;
                     end else begin
                        xs_ff[a] <= vb; xs_ff[b] <= va;
                     end
                  end
                  if (i_ff >= m - CntW'(1)) begin
                     if (sw_ff == m) begin
                        mh = IdxW'(m >> 1);
                        va = ax_ff ? ys_ff[mh] : xs_ff[mh];
                        vb = ax_ff ? ys_ff[IdxW'(mh - IdxW'(1))] : xs_ff[IdxW'(mh - IdxW'(1))];
                        if (m[0]) r = sh8(va);
                        else r = {(17'(va) + 17'(vb)), 7'd0};
                        if (ax_ff) begin
                           ry_ff <= r; rv_ff <= 1'b1; cnt_ff <= '0;
                           state_ff <= S_DONE;
                        end else begin
                           rx_ff <= r; ax_ff <= 1'b1; i_ff <= '0;
                           pass_ff <= 1'b0; sw_ff <= '0;
                        end
                     end else begin
                        i_ff <= CntW'(1);
                        pass_ff <= !pass_ff;
                        sw_ff <= sw_ff + CntW'(1);
                     end
                  end else i_ff <= i_ff + CntW'(1);
               end
            end
            S_MEAN: begin
               if (ii != (ax_ff ? ymi_ff : xmi_ff))
                  sum_ff <= sum_ff + SumW'(cur);
               if (i_ff == m) begin
                  state_ff <= S_DIV;
                  bit_ff <= 6'(SumW + 9);
                  quo_ff <= '0;
               end else i_ff <= i_ff + CntW'(1);
               if (i_ff == m) begin
                  if (ii != (ax_ff ? ymi_ff : xmi_ff))
                     va = cur;
                  else va = '0;
                  rem_ff <= (SumW+9)'(sum_ff + SumW'(va)) <<< 8;
               end
            end
            S_DIV: begin
               // restoring divide, one quotient bit per cycle
               if (bit_ff == 6'(SumW + 9)) begin
                  neg_ff <= rem_ff < 0;
                  rem_ff <= rem_ff < 0 ? -rem_ff : rem_ff;
                  bit_ff <= bit_ff - 6'd1;
               end else begin
                  mag = $unsigned(rem_ff);
                  if ((mag >> bit_ff) >= (SumW+9)'(m)) begin
                     rem_ff <= $signed(mag - ((SumW+9)'(m) << bit_ff));
                     quo_ff <= quo_ff | ((SumW+9)'(1) << bit_ff);
                  end
                  if (bit_ff == 6'd0) begin
                     r = 24'(neg_ff ? -quo_ff - (((mag >= (SumW+9)'(m)) ? 1 : 0))
                                    : quo_ff + (((mag >= (SumW+9)'(m)) ? 1 : 0)));
                     if (ax_ff) begin
                        ry_ff <= r; rv_ff <= 1'b1; cnt_ff <= '0;
                        state_ff <= S_DONE;
                     end else begin
                        rx_ff <= r; ax_ff <= 1'b1; i_ff <= '0;
                        sum_ff <= '0; state_ff <= S_MEAN;
                     end
                  end else bit_ff <= bit_ff - 6'd1;
               end
            end
            S_DONE: if (!rv_ff || !rsp_stall) state_ff <= S_COLLECT;
            default: state_ff <= S_COLLECT;
         endcase
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rsp_stall |=> rv_ff && $stable(rx_ff) && $stable(ry_ff))
      else $error("result changed while stalled");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      take |-> state_ff == S_COLLECT) else $error("sample taken while busy");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(MaxSamples)) else $error("count overflow");

endmodule

// ===== hdl/motion_sample_drop_max_median_mean.sv =====
// Motion burst filter. Readings enter on req_ (one per cycle while the
// two-deep queue is not full); readings of a burst are stored, up to 16. On
// the reading flagged last, a lone reading is returned as it is; otherwise
// each axis drops its first maximum and returns the mean (mode 0) or median
// (mode 1) of the rest, 8 fractional bits, one response per burst.
// For a burst of two or more readings the maxima are found first, then
// each axis is sorted in median mode (one compare-swap a cycle) or summed
// and divided in mean mode (one quotient bit a cycle in the divider); the
// front queue keeps taking readings meanwhile until it fills.
module motion_sample_drop_max_median_mean
   import msd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [14:0] csr_data
);

   logic        mode_ff;
   logic [14:0] reject_ff;
   logic        q_valid, q_ready;
   smp_type     q_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         reject_ff <= ResetReject;
      end else if (csr_valid) begin
         case (csr_index)
            CsrMode:   mode_ff <= csr_data[0];
            CsrReject: reject_ff <= csr_data;
            default: ;
         endcase
      end
   end

   msd_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .reject_limit(reject_ff), .q_valid, .q_ready, .q_data
   );

   msd_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_data, .mode(mode_ff),
      .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule

// ===== verif/motion_sample_drop_max_median_mean_tb.sv =====
`timescale 1ns / 100ps

module motion_sample_drop_max_median_mean_tb;
   import msd_pkg::*;

   localparam int WatchLimit = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = CsrMode;
   logic [14:0] csr_data = '0;

   // predictor state
   logic        pred_mode;
   logic [14:0] pred_reject;
   int          burst_x[$];
   int          burst_y[$];
   logic        burst_motion;

   rsp_type     expected_filtered[$];
   int          fail_count = 0;
   int          burst_count;
   int          read_count;
   int          idle_cycles = 0;
   bit          allow_long_gaps;

   motion_sample_drop_max_median_mean u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   function automatic int random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return allow_long_gaps ? $urandom_range(10, 40) : 0;
   endfunction

   function automatic logic [23:0] drop_max_filter(int samples[$]);
      int rest[$];
      int n, maxi, m, tmp;
      longint sum;
      n = samples.size();
      if (n == 0) return '0;
      if (n == 1) return 24'(longint'(samples[0]) * 256);
      maxi = 0;
      for (int i = 1; i < n; i++)
         if (samples[i] > samples[maxi]) maxi = i;
      for (int i = 0; i < n; i++)
         if (i != maxi) rest.push_back(samples[i]);
      m = rest.size();
      if (pred_mode) begin
         for (int i = 1; i < m; i++)
            for (int j = i; j > 0 && rest[j-1] > rest[j]; j--) begin
               tmp = rest[j]; rest[j] = rest[j-1]; rest[j-1] = tmp;
            end
         if (m % 2 == 0)
            return 24'((longint'(rest[m/2]) + longint'(rest[m/2-1])) * 128);
         return 24'(longint'(rest[m/2]) * 256);
      end
      sum = 0;
      foreach (rest[i]) sum += rest[i];
      return 24'((sum * 256) / m);
   endfunction

   function automatic int clip_delta(logic signed [15:0] d);
      int v;
      v = d;
      return ((v < 0 ? -v : v) > int'(pred_reject)) ? 0 : v;
   endfunction

   task automatic predict_reading(req_type r);
      rsp_type e;
      bit motion;
      motion = (r.status_byte & MotionBit) != 0;
      if (motion) burst_motion = 1'b1;
      if (burst_x.size() < MaxSamples) begin
         burst_x.push_back(motion ? clip_delta(r.raw_x) : 0);
         burst_y.push_back(motion ? clip_delta(r.raw_y) : 0);
      end
      if (r.last_sample) begin
         e.x_value = drop_max_filter(burst_x);
         e.y_value = drop_max_filter(burst_y);
         e.motion_seen = burst_motion;
         expected_filtered.push_back(e);
         burst_x.delete(); burst_y.delete();
         burst_motion = 1'b0;
         burst_count++;
      end
   endtask

   // valid stays up after an accepted reading until a gap or a drain lowers it
   task automatic send_reading(req_type r);
      int gap;
      gap = random_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_reading(r);
      read_count++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_filtered.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [14:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CsrMode) pred_mode = value[0];
      else pred_reject = value;
   endtask

   function automatic req_type make_reading(logic [7:0] st, int x, int y, bit last);
      req_type r;
      r.status_byte = st;
      r.raw_x = 16'(x);
      r.raw_y = 16'(y);
      r.last_sample = last;
      return r;
   endfunction

   function automatic logic signed [15:0] random_delta();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return 16'($signed($urandom_range(0, 600)) - 300);
      if (pick < 8) return 16'($urandom);
      return pick == 8 ? 16'sh7fff : 16'sh8000;
   endfunction

   task automatic send_burst(int len);
      logic [7:0] st;
      for (int i = 0; i < len; i++) begin
         st = 8'($urandom);
         if ($urandom_range(0, 3) != 0) st[7] = 1'b1;
         send_reading(make_reading(st, random_delta(), random_delta(), i == len - 1));
      end
   endtask

   task automatic test_directed_edges();
      // single sample returned as is with motion on, and as zero with motion off
      send_reading(make_reading(8'h80, 100, -100, 1));
      send_reading(make_reading(8'h7f, 5, 5, 1));
      // tie on maximum, odd and even remainders
      send_reading(make_reading(8'h80, 7, -3, 0));
      send_reading(make_reading(8'h80, 7, -3, 0));
      send_reading(make_reading(8'h80, 1, -8, 1));
      send_reading(make_reading(8'hff, -1, 2, 0));
      send_reading(make_reading(8'h80, -2, 250, 0));
      send_reading(make_reading(8'h80, 251, -250, 0));
      send_reading(make_reading(8'h80, -251, 3, 1));
      // field extremes
      send_reading(make_reading(8'hff, 32767, -32768, 0));
      send_reading(make_reading(8'h00, -32768, 32767, 0));
      send_reading(make_reading(8'h80, -5, 0, 1));
   endtask

   task automatic test_overlong_burst();
      send_burst(20);
      send_burst(16);
   endtask

   task automatic test_config_sweep();
      write_csr(CsrMode, 15'd1);
      test_directed_edges();
      write_csr(CsrReject, 15'd32767);
      send_reading(make_reading(8'hff, 32767, -32767, 0));
      send_reading(make_reading(8'h80, -32768, 32767, 0));
      send_reading(make_reading(8'h80, 32767, 32767, 1));
      write_csr(CsrMode, 15'd0);
      send_burst(3);
      write_csr(CsrReject, 15'd0);
      send_burst(4);
      write_csr(CsrReject, 15'd250);
   endtask

   task automatic test_random_bursts();
      int len;
      allow_long_gaps = 1'b1;
      while (read_count < 520) begin
         if ($urandom_range(0, 29) == 0) begin
            write_csr(CsrMode, 15'($urandom_range(0, 1)));
            write_csr(CsrReject, $urandom_range(0, 9) < 7 ? 15'($urandom_range(50, 400))
                                                        : 15'($urandom));
         end
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 8);
         send_burst(len);
         // hold off once until every response is in
         if (burst_count == 40) drain_results();
      end
   endtask

   // receiver stall pattern
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         gap = random_gap();
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_filtered.size() == 0) begin
            $display("%0t: unexpected response x=%0d y=%0d m=%0b", $time,
                     rsp_data.x_value, rsp_data.y_value, rsp_data.motion_seen);
            fail_count++;
         end else begin
            rsp_type e;
            e = expected_filtered.pop_front();
            if (rsp_data.x_value !== e.x_value) begin
               $display("%0t: x_value expected %0d actual %0d", $time,
                        e.x_value, rsp_data.x_value);
               fail_count++;
            end
            if (rsp_data.y_value !== e.y_value) begin
               $display("%0t: y_value expected %0d actual %0d", $time,
                        e.y_value, rsp_data.y_value);
               fail_count++;
            end
            if (rsp_data.motion_seen !== e.motion_seen) begin
               $display("%0t: motion_seen expected %0b actual %0b", $time,
                        e.motion_seen, rsp_data.motion_seen);
               fail_count++;
            end
         end
      end
   end

   // watchdog: cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("%0t: watchdog expired", $time);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      pred_mode = 1'b0;
      pred_reject = ResetReject;
      burst_motion = 1'b0;
      burst_count = 0;
      read_count = 0;
      allow_long_gaps = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_overlong_burst();
      test_config_sweep();
      test_random_bursts();
      drain_results();
      $display("Sent %0d readings in %0d bursts, mean and median modes,", read_count,
               burst_count);
      $display("reject limits from 0 to 32767, overlong bursts and max ties.");
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
